// ----- design/u16u8_pkg.sv -----
// shared types and constants for the utf-16 to utf-8 encoder
// no dependencies; imported by every module of the block
`default_nettype none

package u16u8_pkg;

  localparam int unsigned CuW   = 16;
  localparam int unsigned CapW  = 16;
  localparam int unsigned CpW   = 21;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ILLEGAL   = 2'd1;
  localparam status_t ST_EXHAUSTED = 2'd2;
  localparam status_t ST_TARGET    = 2'd3;

  // one classified code point: up to four bytes, or a single error result
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte
    status_t         status;
    logic            last;      // string ends with this job
  } job_t;

endpackage

`default_nettype wire

// ----- design/u16u8_front.sv -----
// front end: takes code units, pairs surrogates, checks capacity, builds byte jobs
// depends on u16u8_pkg
`default_nettype none

module u16u8_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [15:0]           cfg_output_capacity,
  input  wire logic                  push,
  output      logic                  full,
  input  wire logic [15:0]           in_code_unit,
  input  wire logic                  in_last_unit,
  input  wire logic                  q_full,
  output      logic                  q_push,
  output      u16u8_pkg::job_t       q_wdata
);
  import u16u8_pkg::*;

  logic [CapW-1:0] capacity_r;
  logic [9:0]      pending_high_r, pending_high_nxt;
  logic            pending_valid_r, pending_valid_nxt;
  logic [CapW-1:0] bytes_written_r, bytes_written_nxt;
  logic            halted_r, halted_nxt;

  logic            accept;
  logic            is_high, is_low;
  logic [CpW-1:0]  cp;
  logic [2:0]      nbytes;
  logic [3:0][7:0] enc;
  logic [CapW:0]   total;
  logic            fail;
  job_t            job;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  assign is_high = (in_code_unit[15:10] == 6'b110110);
  assign is_low  = (in_code_unit[15:10] == 6'b110111);

  always_comb begin
    if (pending_valid_r) begin
      cp = {1'b0, pending_high_r, in_code_unit[9:0]} + 21'h10000;
    end else begin
      cp = {5'd0, in_code_unit};
    end
    enc = '0;
    if (cp < 21'h80) begin
      nbytes = 3'd1;
      enc[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      nbytes = 3'd2;
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      nbytes = 3'd3;
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
    end else begin
      nbytes = 3'd4;
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
    end
  end

  assign total = {1'b0, bytes_written_r} + {14'd0, nbytes};

  always_comb begin
    pending_high_nxt  = pending_high_r;
    pending_valid_nxt = pending_valid_r;
    bytes_written_nxt = bytes_written_r;
    halted_nxt        = halted_r;
    q_push            = 1'b0;
    fail              = 1'b0;
    job.bytes         = '0;
    job.last_idx      = 2'd0;
    job.status        = ST_OK;
    job.last          = 1'b1;

    if (accept) begin
      if (halted_r) begin
        // dropping input until the string end
      end else if (pending_valid_r && !is_low) begin
        fail       = 1'b1;
        job.status = ST_ILLEGAL;
      end else if (!pending_valid_r && is_high) begin
        if (in_last_unit) begin
          fail       = 1'b1;
          job.status = ST_EXHAUSTED;
        end else begin
          pending_high_nxt  = in_code_unit[9:0];
          pending_valid_nxt = 1'b1;
        end
      end else if (!pending_valid_r && is_low) begin
        fail       = 1'b1;
        job.status = ST_ILLEGAL;
      end else if (total > {1'b0, capacity_r}) begin
        fail       = 1'b1;
        job.status = ST_TARGET;
      end else begin
        q_push            = 1'b1;
        job.bytes         = enc;
        job.last_idx      = 2'(nbytes - 3'd1);
        job.last          = in_last_unit;
        pending_valid_nxt = 1'b0;
        bytes_written_nxt = total[CapW-1:0];
      end

      if (fail) begin
        q_push            = 1'b1;
        pending_valid_nxt = 1'b0;
        halted_nxt        = 1'b1;
      end
      if (in_last_unit) begin
        pending_high_nxt  = '0;
        pending_valid_nxt = 1'b0;
        bytes_written_nxt = '0;
        halted_nxt        = 1'b0;
      end
    end
  end

  assign q_wdata = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r      <= '1;
      pending_high_r  <= '0;
      pending_valid_r <= 1'b0;
      bytes_written_r <= '0;
      halted_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity_r <= cfg_output_capacity;
      end
      pending_high_r  <= pending_high_nxt;
      pending_valid_r <= pending_valid_nxt;
      bytes_written_r <= bytes_written_nxt;
      halted_r        <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/u16u8_jobq.sv -----
// short job queue between the front end and the byte emitter
// depends on u16u8_pkg
`default_nettype none

module u16u8_jobq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire u16u8_pkg::job_t wr_data,
  output      logic            q_full,
  input  wire logic            rd_en,
  output      u16u8_pkg::job_t rd_data,
  output      logic            q_empty
);
  import u16u8_pkg::*;

  job_t             entries_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]   count_r, count_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == (QPtrW+1)'(QDepth));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/u16u8_back.sv -----
// back end: walks each job one byte per cycle into the output register while the slot is free or popped
// depends on u16u8_pkg
`default_nettype none

module u16u8_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire u16u8_pkg::job_t job,
  input  wire logic            q_empty,
  output      logic            q_pop,
  output      logic            empty,
  input  wire logic            pop,
  output      logic [7:0]      out_byte,
  output      logic [1:0]      out_status,
  output      logic            out_char_end,
  output      logic            out_string_end
);
  import u16u8_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  status_t    status_r;
  logic       char_end_r, string_end_r;
  logic       advance, take, at_end;

  // output slot frees up in the same cycle it is popped
  assign advance = !out_valid_r || pop;
  assign take    = advance && !q_empty;
  assign at_end  = (idx_r == job.last_idx);
  assign q_pop   = take && at_end;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = take;
    end
    if (take) begin
      idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r       <= job.bytes[idx_r];
      status_r     <= job.status;
      char_end_r   <= at_end;
      string_end_r <= at_end && job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty          = !out_valid_r;
  assign out_byte       = byte_r;
  assign out_status     = status_r;
  assign out_char_end   = char_end_r;
  assign out_string_end = string_end_r;

endmodule

`default_nettype wire

// ----- design/utf16_to_utf8_encoder_top.sv -----
// UTF-16 to UTF-8 encoder, top level
// Input channel: push/full with in_code_unit and in_last_unit; a unit transfers
// when push is high and full is low. Output channel: empty/pop; the oldest byte
// result sits on out_byte, out_status, out_char_end, out_string_end while empty
// is low and transfers when pop is high. cfg_output_capacity is written on
// cfg_valid (cfg_ready is always high) and applies to the per-string byte count.
// The job is registered in the queue and its first byte then in the output
// register. The byte emitter gives one output byte per cycle while the receiver
// pops, so a code point gives 1, 2, 3 or 4 bytes (a held high surrogate gives
// no result). Errors give one result with out_byte 0. A four-entry job queue
// lets the front keep taking units while the emitter works or the receiver
// stalls; full rises only when that queue is full. A high surrogate is held in
// the front for the next unit (an error if it is no low one or there is none).
// Reset (rst_n low, synchronous) empties both sides, clears the string state
// and sets the capacity to 65535.
// depends on u16u8_pkg, u16u8_front, u16u8_jobq, u16u8_back
`default_nettype none

module utf16_to_utf8_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_output_capacity,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_last_unit,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [7:0]  out_byte,
  output      logic [1:0]  out_status,
  output      logic        out_char_end,
  output      logic        out_string_end
);
  import u16u8_pkg::*;

  job_t wr_job, rd_job;
  logic q_full, q_empty, q_push, q_pop;

  u16u8_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .push                (push),
    .full                (full),
    .in_code_unit        (in_code_unit),
    .in_last_unit        (in_last_unit),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_wdata             (wr_job)
  );

  u16u8_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (wr_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (rd_job),
    .q_empty (q_empty)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (rd_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_char_end   (out_char_end),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire
